>>> rtl/rlcr_pkg.sv
// Package for the ring log with cursor reader.
// Holds the request types, controller state, command and status structs.
// No dependencies.
package rlcr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CURSOR_W = 32;
    localparam int unsigned MAXB_W   = 7;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef struct packed {
        logic                op;
        logic [BYTE_W-1:0]   log_byte;
        logic [CURSOR_W-1:0] cursor;
        logic [MAXB_W-1:0]   max_bytes;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic                byte_valid;
        logic                last;
        logic [CURSOR_W-1:0] new_cursor;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_SIZE,
        ST_START,
        ST_FETCH,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic capture;
        logic clamp;
        logic size;
        logic start;
        logic fetch;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic last;
    } status_t;

endpackage

>>> rtl/ring_log_with_cursor_reader.sv
// Ring log with cursor reader: byte ring log with a monotonic-cursor reader.
// Top level; instantiates rlcr_ctrl and rlcr_datapath, uses rlcr_pkg.
//
// Usage:
//   The s_ channel takes requests. An append request (op 0) stores log_byte
//   at the head of the ring; appends can follow each other every cycle
//   while no read is in progress. A read request (op 1) carries a cursor in the
//   space of the 32-bit saturating write count and a maximum length.
//   The m_ channel returns one result per byte read, the final one flagged
//   last and carrying the updated cursor; a read with nothing to return
//   gives one empty result.
//   Sequence: a read steps through cursor clamp, sizing and start
//   address, then a ring memory read and a load of the result register for
//   each byte; the load waits while the result register is still full.
//   The single registered read port of the ring is why each byte needs
//   both a read step and a load step.
//   s_ready is low for the whole read; it rises again while the last
//   result still waits in the output register.
//   A stalled receiver holds the result register and the stream simply
//   waits. Reset clears the head and the write count; ring contents are
//   undefined until written.
module ring_log_with_cursor_reader import rlcr_pkg::*; #(
    parameter int unsigned RING_DEPTH = 4096,
    parameter int unsigned MAX_BURST  = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    cmd_t    cmd;
    status_t status;

    rlcr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .op      (s_data.op),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rlcr_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_BURST  (MAX_BURST)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .status  (status)
    );

    a_read_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.op == OP_READ) |=> !s_ready)
        else $error("input accepted right after a read request");

    a_cursor_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> (m_data.new_cursor == '0))
        else $error("cursor on a result that is not last");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.byte_valid) |-> m_data.last)
        else $error("empty result not flagged last");

    a_stream_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> !s_ready)
        else $error("input accepted in the middle of a read stream");

endmodule

>>> rtl/rlcr_ctrl.sv
// Controller state machine for the ring log with cursor reader.
// Sequences read setup and byte streaming; depends on rlcr_pkg.
module rlcr_ctrl import rlcr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    op,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && op == OP_READ) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = ST_SIZE;
            ST_SIZE:  state_next = ST_START;
            ST_START: state_next = ST_FETCH;
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD: begin
                if (status.out_free) begin
                    state_next = status.last ? ST_IDLE : ST_FETCH;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.wr_en   = s_valid && op == OP_APPEND;
                cmd.capture = s_valid && op == OP_READ;
            end
            ST_CLAMP: cmd.clamp = 1'b1;
            ST_SIZE:  cmd.size  = 1'b1;
            ST_START: cmd.start = 1'b1;
            ST_FETCH: cmd.fetch = 1'b1;
            ST_LOAD:  cmd.load  = status.out_free;
            default:  cmd       = '0;
        endcase
    end

endmodule

>>> rtl/rlcr_datapath.sv
// Datapath for the ring log with cursor reader: ring memory, head and count,
// cursor arithmetic and the result register. Depends on rlcr_pkg.
module rlcr_datapath import rlcr_pkg::*; #(
    parameter int unsigned RING_DEPTH = 4096,
    parameter int unsigned MAX_BURST  = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      cmd,
    input  in_item_t  s_data,
    input  logic      m_ready,
    output logic      m_valid,
    output out_item_t m_data,
    output status_t   status
);

    localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
    localparam int unsigned BACK_W = $clog2(RING_DEPTH + 1);
    localparam int unsigned CNT_W  = $clog2(MAX_BURST + 1);
    localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [BACK_W-1:0]   DEPTH_B  = BACK_W'(RING_DEPTH);
    localparam logic [CURSOR_W-1:0] DEPTH_C  = CURSOR_W'(RING_DEPTH);
    localparam logic [MAXB_W-1:0]   BURST_M  = MAXB_W'(MAX_BURST);

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];

    logic [IDX_W-1:0]    wi_reg;
    logic [CURSOR_W-1:0] tw_reg;
    logic [CURSOR_W-1:0] cur_reg;
    logic [CNT_W-1:0]    maxb_reg;
    logic [BACK_W-1:0]   avail_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [CURSOR_W-1:0] end_cur_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [BYTE_W-1:0]   rdata_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_reg;

    logic [CURSOR_W-1:0] oldest;
    logic [CURSOR_W-1:0] avail_full;
    logic                empty;
    logic [CNT_W-1:0]    n_next;
    logic [BACK_W-1:0]   wi_ext;
    logic [BACK_W-1:0]   start_idx;
    logic                last_byte;

    assign oldest     = (tw_reg > DEPTH_C) ? tw_reg - DEPTH_C : '0;
    assign avail_full = tw_reg - cur_reg;
    assign empty      = (cur_reg >= tw_reg) || (maxb_reg == '0);
    assign n_next     = empty ? '0 :
                        (avail_full < CURSOR_W'(maxb_reg)) ? CNT_W'(avail_full) : maxb_reg;
    assign wi_ext     = BACK_W'(wi_reg);
    assign start_idx  = (wi_ext >= avail_reg) ? wi_ext - avail_reg
                                              : wi_ext + DEPTH_B - avail_reg;
    assign last_byte  = rem_reg <= CNT_W'(1);

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            ring_mem[wi_reg] <= s_data.log_byte;
        end
        if (cmd.fetch) begin
            rdata_reg <= ring_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wi_reg <= '0;
            tw_reg <= '0;
        end else if (cmd.wr_en) begin
            wi_reg <= (wi_reg == IDX_LAST) ? '0 : wi_reg + IDX_W'(1);
            if (tw_reg != '1) begin
                tw_reg <= tw_reg + CURSOR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cur_reg  <= s_data.cursor;
            maxb_reg <= (s_data.max_bytes > BURST_M) ? CNT_W'(MAX_BURST)
                                                     : CNT_W'(s_data.max_bytes);
        end
        if (cmd.clamp && cur_reg < oldest) begin
            cur_reg <= oldest;
        end
        if (cmd.size) begin
            avail_reg <= BACK_W'(avail_full);
            n_reg     <= n_next;
        end
        if (cmd.start) begin
            rd_idx_reg  <= IDX_W'(start_idx);
            end_cur_reg <= cur_reg + CURSOR_W'(n_reg);
            rem_reg     <= n_reg;
        end
        if (cmd.load) begin
            out_reg.data_byte  <= (rem_reg != '0) ? rdata_reg : '0;
            out_reg.byte_valid <= rem_reg != '0;
            out_reg.last       <= last_byte;
            out_reg.new_cursor <= last_byte ? end_cur_reg : '0;
            if (rem_reg != '0) begin
                rem_reg    <= rem_reg - CNT_W'(1);
                rd_idx_reg <= (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + IDX_W'(1);
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_data          = out_reg;
    assign status.out_free = !out_valid_reg || m_ready;
    assign status.last     = last_byte;

endmodule

>>> tb/sv/rlcr_log_scoreboard.sv
// Scoreboard for the ring log with cursor reader: keeps its own copy of the log,
// predicts the replies to each accepted read request and checks the m_ channel.
// Depends on rlcr_pkg for the request and reply types.
module rlcr_log_scoreboard import rlcr_pkg::*; #(
    parameter int unsigned RING_DEPTH = 4096,
    parameter int unsigned MAX_BURST  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
    localparam int unsigned MAX_REPORT = 10;

    logic [BYTE_W-1:0]   log_copy [RING_DEPTH];
    logic [IDX_W-1:0]    head;
    logic [CURSOR_W-1:0] written;
    out_item_t           read_replies [$];
    int unsigned         errs;

    task automatic log_append(input logic [BYTE_W-1:0] b);
        log_copy[head] = b;
        head = head + 1'b1;
        if (written != '1) begin
            written = written + 1'b1;
        end
    endtask

    task automatic expect_read(input logic [CURSOR_W-1:0] cursor,
                               input logic [MAXB_W-1:0] max_bytes);
        logic [CURSOR_W-1:0] oldest;
        logic [CURSOR_W-1:0] cur;
        logic [CURSOR_W-1:0] count;
        logic [CURSOR_W-1:0] back;
        logic [IDX_W-1:0]    slot;
        out_item_t           r;
        oldest = (written > RING_DEPTH) ? written - RING_DEPTH : '0;
        cur    = (cursor < oldest) ? oldest : cursor;
        count  = (max_bytes > MAX_BURST) ? MAX_BURST : max_bytes;
        if (cur >= written) begin
            count = '0;
        end else if (written - cur < count) begin
            count = written - cur;
        end
        if (count == 0) begin
            r.data_byte  = '0;
            r.byte_valid = 1'b0;
            r.last       = 1'b1;
            r.new_cursor = cur;
            read_replies.push_back(r);
        end else begin
            for (logic [CURSOR_W-1:0] i = 0; i < count; i++) begin
                back         = written - (cur + i);
                slot         = head - back[IDX_W-1:0];
                r.data_byte  = log_copy[slot];
                r.byte_valid = 1'b1;
                r.last       = (i + 1 == count);
                r.new_cursor = r.last ? cur + count : '0;
                read_replies.push_back(r);
            end
        end
    endtask

    task automatic check_reply(input out_item_t got);
        out_item_t want;
        if (read_replies.size() == 0) begin
            errs++;
            if (errs <= MAX_REPORT) begin
                $display("unexpected reply: byte %02h valid %0b last %0b cursor %08h",
                         got.data_byte, got.byte_valid, got.last, got.new_cursor);
            end
            return;
        end
        want = read_replies.pop_front();
        if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
            got.last !== want.last || got.new_cursor !== want.new_cursor) begin
            errs++;
            if (errs <= MAX_REPORT) begin
                $display("reply mismatch: expected byte %02h valid %0b last %0b cursor %08h, got byte %02h valid %0b last %0b cursor %08h",
                         want.data_byte, want.byte_valid, want.last, want.new_cursor,
                         got.data_byte, got.byte_valid, got.last, got.new_cursor);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            head    = '0;
            written = '0;
            errs    = 0;
            read_replies.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_data.op == OP_APPEND) begin
                    log_append(s_data.log_byte);
                end else begin
                    expect_read(s_data.cursor, s_data.max_bytes);
                end
            end
            if (m_valid && m_ready) begin
                check_reply(m_data);
            end
        end
        mismatches  <= errs;
        outstanding <= read_replies.size();
    end

endmodule

>>> tb/sv/ring_log_with_cursor_reader_test.sv
// Top of the ring log with cursor reader testbench: clock, reset, request
// stimulus, reply-side backpressure and the verdict.
// Depends on rlcr_pkg, ring_log_with_cursor_reader and rlcr_log_scoreboard.
module ring_log_with_cursor_reader_test;
    import rlcr_pkg::*;

    localparam int unsigned RING_DEPTH     = 4096;
    localparam int unsigned MAX_BURST      = 64;
    localparam int unsigned RANDOM_ITEMS   = 208;
    localparam int unsigned PHASES         = 4;
    localparam int unsigned LONG_HOLD      = 600;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES    = 40;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int unsigned         mismatches;
    int unsigned         outstanding;
    logic [CURSOR_W-1:0] appended;
    logic [CURSOR_W-1:0] reader_pos;
    bit                  tx_calm = 1'b0;
    bit                  rx_calm = 1'b0;
    int unsigned         hold_asks = 0;
    int unsigned         hold_done = 0;
    int unsigned         stall_left = 0;

    ring_log_with_cursor_reader #(
        .RING_DEPTH(RING_DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    rlcr_log_scoreboard #(
        .RING_DEPTH(RING_DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_scoreboard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls, calm stretches, and one long hold on request
    always @(posedge aclk) begin
        if (hold_done != hold_asks) begin
            hold_done  <= hold_asks;
            m_ready    <= 1'b0;
            stall_left <= LONG_HOLD;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) begin
                m_ready <= 1'b1;
            end
        end else if (rx_calm || $urandom_range(0, 3) != 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready    <= 1'b0;
            stall_left <= idle_span();
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL ring_log_with_cursor_reader");
        $finish;
    end

    task automatic offer(input in_item_t req);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        if (req.op == OP_APPEND) begin
            appended = appended + 1'b1;
        end
        gap = tx_calm ? 0 : idle_span();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_append(input logic [BYTE_W-1:0] b);
        in_item_t req;
        req.op        = OP_APPEND;
        req.log_byte  = b;
        req.cursor    = $urandom;
        req.max_bytes = MAXB_W'($urandom);
        offer(req);
    endtask

    task automatic send_read(input logic [CURSOR_W-1:0] cur, input logic [MAXB_W-1:0] len);
        in_item_t            req;
        logic [CURSOR_W-1:0] lo;
        logic [CURSOR_W-1:0] lim;
        req.op        = OP_READ;
        req.log_byte  = BYTE_W'($urandom);
        req.cursor    = cur;
        req.max_bytes = len;
        offer(req);
        // advance the follow-on cursor the way a well-behaved reader would
        lo  = (appended > RING_DEPTH) ? appended - RING_DEPTH : '0;
        lim = (len > MAX_BURST) ? MAX_BURST : len;
        if (cur < lo) cur = lo;
        if (cur < appended) begin
            reader_pos = (appended - cur < lim) ? appended : cur + lim;
        end else if (cur == appended) begin
            reader_pos = cur;
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int unsigned         sent;
        int unsigned         r;
        int unsigned         burst;
        logic [MAXB_W-1:0]   len;
        logic [CURSOR_W-1:0] cur;
        appended   = '0;
        reader_pos = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty log, extremes of every field, clamping and caught-up reads
        send_read(32'd0, 7'd64);
        send_read(32'hFFFF_FFFF, 7'd0);
        send_append(8'h00);
        send_append(8'hFF);
        send_append(8'hA5);
        send_append(8'h5A);
        repeat (6) send_append(BYTE_W'($urandom));
        send_read(32'd0, 7'd0);
        send_read(32'd0, 7'd3);
        send_read(32'd3, 7'd127);
        send_read(32'd10, 7'd5);
        send_read(32'd2, 7'd64);
        send_read(32'h8000_0000, 7'd1);
        send_read(32'd1, 7'd63);
        send_read(32'd9, 7'd65);
        settle();

        // cursors one ring depth back from the head and just below it
        send_read(32'd0, 7'd64);
        send_read(appended - RING_DEPTH, 7'd64);
        send_read(appended - RING_DEPTH - 1, 7'd16);
        send_read(appended - 1, 7'd64);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            tx_calm = (phase == 0);
            rx_calm = (phase == 0);
            sent    = 0;
            if (phase == 2) begin
                hold_asks++;
                send_read(appended - MAX_BURST, 7'd64);
                sent++;
            end
            while (sent < RANDOM_ITEMS / PHASES) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    burst = $urandom_range(1, 12);
                    repeat (burst) send_append(BYTE_W'($urandom));
                    sent += burst;
                end else begin
                    len = ($urandom_range(0, 99) < 70) ? MAXB_W'($urandom_range(1, 16))
                                                       : MAXB_W'($urandom);
                    if (r < 65) begin
                        cur = reader_pos;
                    end else if (r < 80) begin
                        cur = appended - $urandom_range(0, RING_DEPTH + 200);
                    end else if (r < 88) begin
                        cur = $urandom;
                    end else if (r < 94) begin
                        cur = '0;
                    end else begin
                        cur = appended + $urandom_range(0, 3);
                    end
                    send_read(cur, len);
                    sent++;
                end
            end
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS ring_log_with_cursor_reader");
        end else begin
            $display("FAIL ring_log_with_cursor_reader");
        end
        $finish;
    end

endmodule
